// ===== rtl/bxp_pkg.sv =====
`timescale 1ns / 1ps
// bxp_pkg: constants, word types and control structs for the binarized dense layer
// used by every file of the block but bxp_ram; depends on nothing

package bxp_pkg;

    localparam int NUM_INPUTS  = 64;
    localparam int NUM_NEURONS = 32;

    localparam int DATA_W  = 64;
    localparam int ROW_AW  = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
    localparam logic [DATA_W-1:0] INPUT_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_INPUTS);

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [4:0]        row_index;
        logic [DATA_W-1:0] data_bits;
    } in_word_t;

    typedef struct packed {
        logic [4:0]        neuron_index;
        logic signed [7:0] neuron_sum;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic              issue;
        logic [ROW_AW-1:0] addr;
        logic              last;
        logic              load_we;
        logic              act_we;
    } cmd_t;

    typedef struct packed {
        logic advance;
        logic busy;
    } stat_t;

endpackage

// ===== rtl/bxp_ram.sv =====
`timescale 1ns / 1ps
// bxp_ram: generic single write port ram with registered read
// no dependencies

module bxp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bxp_ctrl.sv =====
`timescale 1ns / 1ps
// bxp_ctrl: request handshake and neuron sequencer
// depends on bxp_pkg

module bxp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_type,
    input  logic [4:0]       row_index,
    input  bxp_pkg::stat_t   stat,
    output bxp_pkg::cmd_t    cmd
);

    typedef enum logic {
        IDLE,
        RUN
    } state_t;

    state_t                     state_reg, state_next;
    logic [bxp_pkg::ROW_AW-1:0] cnt_reg, cnt_next;
    logic                       accept;
    logic                       at_last;

    assign req_ready = (state_reg == IDLE) && !stat.busy;
    assign accept    = req_valid && req_ready;
    assign at_last   = (cnt_reg == bxp_pkg::ROW_AW'(bxp_pkg::NUM_NEURONS - 1));

    always_comb
    begin
        cmd.issue   = (state_reg == RUN) && stat.advance;
        cmd.addr    = cnt_reg;
        cmd.last    = at_last;
        cmd.load_we = accept && (req_type == bxp_pkg::REQ_LOAD)
                      && (int'(row_index) < bxp_pkg::NUM_NEURONS);
        cmd.act_we  = accept && (req_type == bxp_pkg::REQ_COMPUTE);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            IDLE:
            begin
                if (cmd.act_we)
                begin
                    state_next = RUN;
                    cnt_next   = '0;
                end
            end
            RUN:
            begin
                if (cmd.issue)
                begin
                    if (at_last)
                    begin
                        state_next = IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/bxp_datapath.sv =====
`timescale 1ns / 1ps
// bxp_datapath: weight store, activation register, xnor/popcount pipeline, output word
// depends on bxp_pkg and bxp_ram

module bxp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bxp_pkg::in_word_t   req_word,
    input  bxp_pkg::cmd_t       cmd,
    output bxp_pkg::stat_t      stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bxp_pkg::out_word_t  rsp_word
);

    localparam int NBYTES = bxp_pkg::DATA_W / 8;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    logic [bxp_pkg::NUM_NEURONS-1:0] row_ok_reg;
    logic [bxp_pkg::DATA_W-1:0]      act_reg;
    logic [bxp_pkg::DATA_W-1:0]      ram_q;

    logic                       a_valid_reg;
    logic                       a_hit_reg;
    logic [bxp_pkg::ROW_AW-1:0] a_idx_reg;
    logic                       a_last_reg;

    logic                       b_valid_reg;
    logic [3:0]                 b_cnt_reg [NBYTES];
    logic [bxp_pkg::ROW_AW-1:0] b_idx_reg;
    logic                       b_last_reg;

    logic                       out_valid_reg;
    bxp_pkg::out_word_t         out_word_reg;

    logic                       advance;
    logic [bxp_pkg::DATA_W-1:0] weights;
    logic [bxp_pkg::DATA_W-1:0] match;
    logic [6:0]                 total;

    assign advance      = !out_valid_reg || rsp_ready;
    assign stat.advance = advance;
    assign stat.busy    = a_valid_reg || b_valid_reg;

    bxp_ram #(
        .WIDTH (bxp_pkg::DATA_W),
        .DEPTH (bxp_pkg::NUM_NEURONS)
    ) u_rows (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (bxp_pkg::ROW_AW'(req_word.row_index)),
        .wdata (req_word.data_bits),
        .re    (cmd.issue),
        .raddr (cmd.addr),
        .rdata (ram_q)
    );

    // rows never loaded read as zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
        end
        else if (cmd.load_we)
        begin
            row_ok_reg[bxp_pkg::ROW_AW'(req_word.row_index)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act_we)
        begin
            act_reg <= req_word.data_bits;
        end
    end

    assign weights = a_hit_reg ? ram_q : '0;
    assign match   = ~(act_reg ^ weights) & bxp_pkg::INPUT_MASK;

    always_comb
    begin
        total = '0;
        for (int i = 0; i < NBYTES; i++)
        begin
            total = total + 7'(b_cnt_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= cmd.issue;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_hit_reg  <= row_ok_reg[cmd.addr];
            a_idx_reg  <= cmd.addr;
            a_last_reg <= cmd.last;
            for (int i = 0; i < NBYTES; i++)
            begin
                b_cnt_reg[i] <= byte_ones(match[i*8 +: 8]);
            end
            b_idx_reg  <= a_idx_reg;
            b_last_reg <= a_last_reg;
            out_word_reg.neuron_index <= 5'(b_idx_reg);
            out_word_reg.neuron_sum   <= $signed({total, 1'b0} - 8'(bxp_pkg::NUM_INPUTS));
            out_word_reg.last         <= b_last_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

// ===== rtl/binary_xnor_popcount_dense_layer.sv =====
`timescale 1ns / 1ps
// binary_xnor_popcount_dense_layer: top level of the binarized dense layer
// depends on bxp_pkg, bxp_ctrl, bxp_datapath, bxp_ram
// load word: row written at acceptance
// compute word: one result per cycle (32 neurons) unless stalled, paced by the single
// read port of the weight ram; the next word waits for idle and empty stages a and b
// reset: all weight rows read as zero (valid bit per row), pipeline and output emptied

module binary_xnor_popcount_dense_layer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bxp_pkg::in_word_t   req_word,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bxp_pkg::out_word_t  rsp_word
);

    bxp_pkg::cmd_t  cmd;
    bxp_pkg::stat_t stat;

    bxp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_word.req_type),
        .row_index (req_word.row_index),
        .stat      (stat),
        .cmd       (cmd)
    );

    bxp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule

// ===== rtl/bxp_checker.sv =====
`timescale 1ns / 1ps
// bxp_checker: port level checks for the binarized dense layer, bound to the top level
// depends on bxp_pkg

module bxp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input bxp_pkg::in_word_t   req_word,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input bxp_pkg::out_word_t  rsp_word
);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    // last mark only on the final neuron
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.last ==
            (rsp_word.neuron_index == 5'(bxp_pkg::NUM_NEURONS - 1))))
        else $error("last mark on wrong neuron");

    // sum within range and of the right parity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.neuron_sum >= -8'sd64) && (rsp_word.neuron_sum <= 8'sd64)
            && (rsp_word.neuron_sum[0] == 1'(bxp_pkg::NUM_INPUTS)))
        else $error("neuron sum out of range");

    // neurons come out in order within a compute word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_word.last |=>
            !rsp_valid || (rsp_word.neuron_index == 5'($past(rsp_word.neuron_index) + 1'b1)))
        else $error("neuron order broken");

endmodule

bind binary_xnor_popcount_dense_layer bxp_checker u_bxp_checker (.*);

// ===== dv/bxp_layer_checker.sv =====
`timescale 1ns / 1ps
// bxp_layer_checker: watches both word channels of the binarized dense layer,
// predicts every neuron result from a shadow of the weight rows and compares it
// depends on bxp_pkg

module bxp_layer_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  bxp_pkg::in_word_t   req_word,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  bxp_pkg::out_word_t  rsp_word,
    output int                  fail_count,
    output int                  sums_due
);

    import bxp_pkg::*;

    logic [DATA_W-1:0] row_shadow [NUM_NEURONS];
    out_word_t         sum_queue [$];
    int                errs;

    function automatic logic signed [7:0] neuron_score(input logic [DATA_W-1:0] act,
                                                        input logic [DATA_W-1:0] wrow);
        logic [DATA_W-1:0] agree;
        logic signed [31:0] total;
        int ones;
        agree = ~(act ^ wrow) & INPUT_MASK;
        ones = 0;
        for (int i = 0; i < DATA_W; i++)
        begin
            ones += agree[i];
        end
        total = 2 * ones - NUM_INPUTS;
        return total[7:0];
    endfunction

    initial
    begin
        errs = 0;
        fail_count = 0;
        sums_due = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t due;
        out_word_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NEURONS; i++)
            begin
                row_shadow[i] = '0;
            end
            sum_queue.delete();
            sums_due <= 0;
        end
        else
        begin
            // results leave first: a compute word taken now cannot answer at this edge
            if (rsp_valid && rsp_ready)
            begin
                if (sum_queue.size() == 0)
                begin
                    errs++;
                    $display("%0t unexpected result word: expected none, got idx %0d sum %0d last %0b",
                             $time, rsp_word.neuron_index, $signed(rsp_word.neuron_sum),
                             rsp_word.last);
                end
                else
                begin
                    due = sum_queue.pop_front();
                    if (rsp_word.neuron_index !== due.neuron_index ||
                        rsp_word.neuron_sum !== due.neuron_sum ||
                        rsp_word.last !== due.last)
                    begin
                        errs++;
                        $display("%0t result mismatch: expected idx %0d sum %0d last %0b, got idx %0d sum %0d last %0b",
                                 $time, due.neuron_index, $signed(due.neuron_sum), due.last,
                                 rsp_word.neuron_index, $signed(rsp_word.neuron_sum),
                                 rsp_word.last);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (req_word.req_type == REQ_LOAD)
                begin
                    if (req_word.row_index < NUM_NEURONS)
                    begin
                        row_shadow[req_word.row_index] = req_word.data_bits & INPUT_MASK;
                    end
                end
                else
                begin
                    for (int n = 0; n < NUM_NEURONS; n++)
                    begin
                        fresh.neuron_index = n[4:0];
                        fresh.neuron_sum = neuron_score(req_word.data_bits, row_shadow[n]);
                        fresh.last = (n == NUM_NEURONS - 1);
                        sum_queue.push_back(fresh);
                    end
                end
            end
            sums_due <= sum_queue.size();
        end
        fail_count <= errs;
    end

endmodule

// ===== dv/binary_xnor_popcount_dense_layer_tb.sv =====
`timescale 1ns / 1ps
// binary_xnor_popcount_dense_layer_tb: drives load and compute words in bursts,
// stalls the result channel and gives the verdict from the checker's count
// depends on bxp_pkg, bxp_layer_checker and the binarized dense layer rtl

module binary_xnor_popcount_dense_layer_tb;

    import bxp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 160;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_word_t  req_word;
    logic      rsp_valid;
    logic      rsp_ready;
    out_word_t rsp_word;

    int fail_count;
    int sums_due;
    int cycle_count;
    int burst_left;
    int stall_mode;
    int mode_left;

    binary_xnor_popcount_dense_layer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    bxp_layer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word),
        .fail_count (fail_count),
        .sums_due   (sums_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern, switching mode at random intervals
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ((cycle_count % 9) < 5);
        endcase
    end

    function automatic logic [DATA_W-1:0] pick_bits();
        int k;
        k = $urandom_range(0, DATA_W - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {{(DATA_W-1){1'b0}}, 1'b1} << k;
            3:       return ~({{(DATA_W-1){1'b0}}, 1'b1} << k);
            4:       return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic kind, input logic [4:0] row,
                             input logic [DATA_W-1:0] bits);
        in_word_t w;
        w.req_type = kind;
        w.row_index = row;
        w.data_bits = bits;
        req_word <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(20, 40);
            else
                burst_left = $urandom_range(1, 8);
            req_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 45)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_results_done();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sums_due != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        rsp_ready = 1'b0;
        cycle_count = 0;
        stall_mode = 0;
        mode_left = 0;
        burst_left = 3;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rows still cleared from reset
        send_word(REQ_COMPUTE, 5'd0, '0);
        send_word(REQ_COMPUTE, 5'd0, '1);
        send_word(REQ_LOAD, 5'd0, '1);
        send_word(REQ_LOAD, 5'd31, 64'h8000_0000_0000_0001);
        send_word(REQ_LOAD, 5'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(REQ_LOAD, 5'd2, 64'h5555_5555_5555_5555);
        send_word(REQ_LOAD, 5'd30, 64'hFFFF_FFFF_0000_0000);
        send_word(REQ_COMPUTE, 5'd31, '1);
        send_word(REQ_COMPUTE, 5'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        // same activations again: no carry-over between words
        send_word(REQ_COMPUTE, 5'd21, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_results_done();
        send_word(REQ_LOAD, 5'd5, 64'h0123_4567_89AB_CDEF);
        send_word(REQ_COMPUTE, 5'd10, 64'h0123_4567_89AB_CDEF);
        send_word(REQ_COMPUTE, 5'd0, '0);
        send_word(REQ_LOAD, 5'd0, '0);
        send_word(REQ_COMPUTE, 5'd17, 64'hFEDC_BA98_7654_3210);
        wait_results_done();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                wait_results_done();
            if ($urandom_range(0, 9) < 6)
                send_word(REQ_LOAD, 5'($urandom_range(0, 31)), pick_bits());
            else
                send_word(REQ_COMPUTE, 5'($urandom_range(0, 31)), pick_bits());
        end

        wait_results_done();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bxp_pkg.sv
rtl/bxp_ram.sv
rtl/bxp_ctrl.sv
rtl/bxp_datapath.sv
rtl/binary_xnor_popcount_dense_layer.sv
rtl/bxp_checker.sv
dv/bxp_layer_checker.sv
dv/binary_xnor_popcount_dense_layer_tb.sv
